// ===== sv/masked_length_frame_deframer_assert.svh =====
// Assertion macros shared by the deframer RTL files.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef MASKED_LENGTH_FRAME_DEFRAMER_ASSERT_SVH
`define MASKED_LENGTH_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MLFD_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MLFD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/mlfd_pkg.sv =====
// Package for the masked-length frame deframer: sizes, reset values,
// phase and register codes, and the structs passed between modules.
// No dependencies.
package mlfd_pkg;

  localparam int LEN_BITS     = 32;
  localparam int HEADER_BYTES = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int MAX_LEN_W    = 32;

  localparam logic [63:0] MASK_RESET   = 64'h0000_0000_2024_0828;
  localparam logic [31:0] MAXLEN_RESET = 32'd65535;
  // Largest value a length counter can hold.
  localparam logic [63:0] LEN_CNT_MAX  = {64{1'b1}} >> (64 - LEN_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_MASK    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NOISE  = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef struct packed {
    logic                bad;
    logic [LEN_BITS-1:0] noise_cnt;
    logic [LEN_BITS-1:0] body_cnt;
  } hdr_res_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       last;
    logic       empty;
    logic       bad;
  } result_t;

endpackage

// ===== sv/masked_length_frame_deframer.sv =====
// Masked-length frame deframer, top level: configuration registers, input
// register and result register around the frame state logic.
// Depends on mlfd_pkg and mlfd_ctrl.
//
// Usage:
//   in_*  : byte stream, one byte per transaction in in_tdata.
//   out_* : one transaction per body byte (out_tdata), with out_tlast on the
//           last result of a frame. out_tuser flags an empty-body frame or a
//           rejected header; those results carry zero data and out_tlast set.
//   cfg_* : register writes, always ready. Index 0 is the 64-bit length mask,
//           index 1 the largest accepted total frame length. Other indexes
//           are ignored. Write only while no result is pending.
// Path: an accepted byte goes through the input register, then the result
//   register, before its result appears at out_*.
// Throughput: one byte per cycle while the receiver keeps out_tready high;
//   the header check and counter updates are combinational between them.
// Reset (rst_n low, synchronous) empties both registers, restores the
//   register defaults and restarts header collection.
// When the receiver stalls, the result register holds its transaction and
//   the input register keeps one byte; in_tready drops only when both are full.
`include "masked_length_frame_deframer_assert.svh"

module masked_length_frame_deframer import mlfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] in_byte
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] body_byte
  output logic                  out_tlast,
  output logic [1:0]            out_tuser,  // [0] empty_frame, [1] bad_header
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [63:0]          magic_mask_r;
  logic [MAX_LEN_W-1:0] max_frame_len_r;
  logic                 in_valid_r;
  logic [7:0]           in_byte_r;
  logic                 out_valid_r;
  result_t              out_res_r;
  logic                 out_free;
  logic                 step;
  logic                 in_fire;
  logic                 res_valid;
  result_t              res;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_mask_r    <= MASK_RESET;
      max_frame_len_r <= MAXLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAGIC_MASK:    magic_mask_r    <= cfg_data[63:0];
        REG_MAX_FRAME_LEN: max_frame_len_r <= cfg_data[MAX_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (step) begin
        in_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= step && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_tdata;
    end
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  mlfd_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .byte_i        (in_byte_r),
    .magic_mask    (magic_mask_r),
    .max_frame_len (max_frame_len_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.body_byte;
  assign out_tlast  = out_res_r.last;
  assign out_tuser  = {out_res_r.bad, out_res_r.empty};

  `MLFD_ASSERT_NEXT(a_in_reg_holds, in_valid_r && !step && !in_fire,
    in_valid_r && $stable(in_byte_r), "buffered input byte lost while stalled")
  `MLFD_ASSERT_NOW(a_flags_exclusive, out_valid_r, !(out_res_r.bad && out_res_r.empty),
    "result flagged both empty and bad")
  `MLFD_ASSERT_NOW(a_flagged_no_data, out_valid_r && (out_res_r.bad || out_res_r.empty),
    out_res_r.body_byte == 8'd0 && out_res_r.last, "flagged result carries data or no tlast")

endmodule

// ===== sv/mlfd_hdr_chk.sv =====
// Header check for the deframer: unmasks the two length words, validates
// them and derives the noise and body lengths. Depends on mlfd_pkg.
module mlfd_hdr_chk import mlfd_pkg::*; (
  input  logic [63:0]          total_raw,
  input  logic [63:0]          noise_raw,
  input  logic [63:0]          magic_mask,
  input  logic [MAX_LEN_W-1:0] max_frame_len,
  output hdr_res_t             hdr
);

  logic [63:0] total;
  logic [63:0] noise;
  logic [63:0] cfg_len;
  logic [63:0] limit;
  logic [63:0] total_m16;
  logic [63:0] body64;

  always_comb begin
    total     = total_raw ^ magic_mask;
    noise     = noise_raw ^ magic_mask;
    cfg_len   = 64'(max_frame_len);
    limit     = (cfg_len < LEN_CNT_MAX) ? cfg_len : LEN_CNT_MAX;
    total_m16 = total - 64'(HEADER_BYTES);
    body64    = total_m16 - noise;
    // Once the total is known to be at least the header size, comparing the
    // noise against total minus header cannot wrap.
    hdr.bad       = (total < 64'(HEADER_BYTES)) || (noise > total_m16) || (total > limit);
    hdr.noise_cnt = noise[LEN_BITS-1:0];
    hdr.body_cnt  = body64[LEN_BITS-1:0];
  end

endmodule

// ===== sv/mlfd_ctrl.sv =====
// Frame state for the deframer: header shift registers, noise and body
// counters and the phase machine. Depends on mlfd_pkg and mlfd_hdr_chk.
`include "masked_length_frame_deframer_assert.svh"

module mlfd_ctrl import mlfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           byte_i,
  input  logic [63:0]          magic_mask,
  input  logic [MAX_LEN_W-1:0] max_frame_len,
  output logic                 res_valid,
  output result_t              res
);

  phase_t              phase_r, phase_nxt;
  logic [3:0]          hdr_cnt_r, hdr_cnt_nxt;
  logic [63:0]         total_word_r, total_word_nxt;
  logic [63:0]         noise_word_r, noise_word_nxt;
  logic [LEN_BITS-1:0] noise_left_r, noise_left_nxt;
  logic [LEN_BITS-1:0] body_left_r, body_left_nxt;
  logic [63:0]         noise_full;
  hdr_res_t            hdr;

  // The sixteenth header byte completes the noise word.
  assign noise_full = {noise_word_r[55:0], byte_i};

  mlfd_hdr_chk u_hdr_chk (
    .total_raw     (total_word_r),
    .noise_raw     (noise_full),
    .magic_mask    (magic_mask),
    .max_frame_len (max_frame_len),
    .hdr           (hdr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hdr_cnt_r    <= '0;
      noise_left_r <= '0;
      body_left_r  <= '0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      noise_left_r <= noise_left_nxt;
      body_left_r  <= body_left_nxt;
    end
  end

  // Both words are fully refilled before each use, so they need no reset.
  always_ff @(posedge clk) begin
    total_word_r <= total_word_nxt;
    noise_word_r <= noise_word_nxt;
  end

  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    total_word_nxt = total_word_r;
    noise_word_nxt = noise_word_r;
    noise_left_nxt = noise_left_r;
    body_left_nxt  = body_left_r;
    res_valid      = 1'b0;
    res            = '0;
    if (step) begin
      case (phase_r)
        PH_NOISE: begin
          noise_left_nxt = noise_left_r - LEN_BITS'(1);
          if (noise_left_nxt == '0) begin
            if (body_left_r == '0) begin
              phase_nxt = PH_HEADER;
              res_valid = 1'b1;
              res.last  = 1'b1;
              res.empty = 1'b1;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          body_left_nxt = body_left_r - LEN_BITS'(1);
          res_valid     = 1'b1;
          res.body_byte = byte_i;
          if (body_left_nxt == '0) begin
            phase_nxt = PH_HEADER;
            res.last  = 1'b1;
          end
        end
        default: begin
          phase_nxt   = PH_HEADER;
          hdr_cnt_nxt = hdr_cnt_r + 4'd1;
          if (!hdr_cnt_r[3]) begin
            total_word_nxt = {total_word_r[55:0], byte_i};
          end else begin
            noise_word_nxt = noise_full;
          end
          if (hdr_cnt_r == 4'hF) begin
            if (hdr.bad) begin
              noise_left_nxt = '0;
              body_left_nxt  = '0;
              res_valid      = 1'b1;
              res.last       = 1'b1;
              res.bad        = 1'b1;
            end else begin
              noise_left_nxt = hdr.noise_cnt;
              body_left_nxt  = hdr.body_cnt;
              if (hdr.noise_cnt != '0) begin
                phase_nxt = PH_NOISE;
              end else if (hdr.body_cnt == '0) begin
                res_valid = 1'b1;
                res.last  = 1'b1;
                res.empty = 1'b1;
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end
        end
      endcase
    end
  end

  `MLFD_ASSERT_NOW(a_noise_cnt_live, phase_r == PH_NOISE, noise_left_r != '0,
    "noise phase entered with an exhausted noise counter")
  `MLFD_ASSERT_NOW(a_body_cnt_live, phase_r == PH_BODY, body_left_r != '0,
    "body phase entered with an exhausted body counter")
  `MLFD_ASSERT_NOW(a_bad_is_final, res_valid && res.bad, res.last && !res.empty,
    "error result must end the frame and not be marked empty")
  `MLFD_ASSERT_NEXT(a_result_back_to_header, res_valid && res.last, phase_r == PH_HEADER,
    "block did not return to header collection after a frame end")

endmodule

// ===== sim/deframer_sb_pkg.sv =====
// Result scoreboard for the masked-length frame deframer testbench.
// Holds a cycle-free copy of the frame state and the results still due.
// Depends on mlfd_pkg.
package deframer_sb_pkg;
  import mlfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] HDR_LEN = 64'(HEADER_BYTES);

  class deframer_scoreboard;
    logic [63:0] len_mask;
    logic [31:0] len_max;
    phase_t      stage;
    logic [3:0]  hdr_count;
    logic [63:0] total_raw;
    logic [63:0] noise_raw;
    logic [63:0] noise_rem;
    logic [63:0] body_rem;
    result_t     due_results[$];
    int          errors;

    function new();
      len_mask  = MASK_RESET;
      len_max   = MAXLEN_RESET;
      stage     = PH_HEADER;
      hdr_count = '0;
      total_raw = '0;
      noise_raw = '0;
      noise_rem = '0;
      body_rem  = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_MAGIC_MASK) begin
        len_mask = value;
      end else if (idx == REG_MAX_FRAME_LEN) begin
        len_max = value[MAX_LEN_W-1:0];
      end
    endfunction

    function void queue_result(logic [7:0] b, logic last, logic empty, logic bad);
      result_t r;
      r.body_byte = b;
      r.last      = last;
      r.empty     = empty;
      r.bad       = bad;
      due_results = {due_results, r};
    endfunction

    // Advances the frame state by one accepted stream byte.
    function void take_byte(logic [7:0] b);
      logic [63:0] total;
      logic [63:0] noise;
      logic [63:0] limit;
      logic        reject;
      case (stage)
        PH_NOISE: begin
          noise_rem = noise_rem - 1;
          if (noise_rem == 0) begin
            if (body_rem == 0) begin
              stage = PH_HEADER;
              queue_result(8'h00, 1'b1, 1'b1, 1'b0);
            end else begin
              stage = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          body_rem = body_rem - 1;
          if (body_rem == 0) stage = PH_HEADER;
          queue_result(b, body_rem == 0, 1'b0, 1'b0);
        end
        default: begin
          stage = PH_HEADER;
          if (hdr_count < 8) total_raw = {total_raw[55:0], b};
          else noise_raw = {noise_raw[55:0], b};
          hdr_count = hdr_count + 4'd1;
          if (hdr_count == 0) begin
            total = total_raw ^ len_mask;
            noise = noise_raw ^ len_mask;
            limit = (64'(len_max) < LEN_CNT_MAX) ? 64'(len_max) : LEN_CNT_MAX;
            // The noise test only runs once total is known to cover the header.
            if (total < HDR_LEN) reject = 1'b1;
            else reject = (noise > total - HDR_LEN) || (total > limit);
            if (reject) begin
              noise_rem = '0;
              body_rem  = '0;
              queue_result(8'h00, 1'b1, 1'b0, 1'b1);
            end else begin
              noise_rem = noise;
              body_rem  = total - noise - HDR_LEN;
              if (noise_rem != 0) stage = PH_NOISE;
              else if (body_rem == 0) queue_result(8'h00, 1'b1, 1'b1, 1'b0);
              else stage = PH_BODY;
            end
          end
        end
      endcase
    endfunction

    function void check_result(logic [7:0] data, logic last, logic [1:0] flags);
      result_t got;
      result_t want;
      got.body_byte = data;
      got.last      = last;
      got.empty     = flags[0];
      got.bad       = flags[1];
      if (due_results.size() == 0) begin
        $display("%0t ns: result with none due: data=%h last=%b empty=%b bad=%b",
                 $time, got.body_byte, got.last, got.empty, got.bad);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got !== want) begin
        $display("%0t ns: result mismatch: expected data=%h last=%b empty=%b bad=%b",
                 $time, want.body_byte, want.last, want.empty, want.bad);
        $display("%0t ns:                    actual data=%h last=%b empty=%b bad=%b",
                 $time, got.body_byte, got.last, got.empty, got.bad);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== sim/tb_masked_length_frame_deframer.sv =====
// Top-level testbench for the masked-length frame deframer: drives framed
// byte streams and register writes, and checks every result transaction.
// Depends on mlfd_pkg, deframer_sb_pkg and masked_length_frame_deframer.
module tb_masked_length_frame_deframer;
  import mlfd_pkg::*;
  import deframer_sb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Indexes the block has no register for.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  out_tlast;
  logic [1:0]            out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bytes_sent     = 0;

  deframer_scoreboard sb = new();

  masked_length_frame_deframer dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [7:0] stream_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Leaves in_tvalid high after the transaction; the next call drives a new
  // byte or idles first, and settle_block takes it down at the following falling edge.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits for every due result, then for the bytes still in the pipeline.
  task automatic settle_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Sends a header for the given lengths followed by payload_len bytes.
  task automatic send_frame(input logic [63:0] total, input logic [63:0] noise,
                            input int payload_len);
    logic [63:0] word;
    int          pad;
    // A partly collected header is filled up first so the new frame lines up.
    if (sb.stage == PH_HEADER && sb.hdr_count != 0) begin
      pad = HEADER_BYTES - int'(sb.hdr_count);
      repeat (pad) send_byte(stream_byte());
    end
    for (int i = 0; i < HEADER_BYTES; i++) begin
      word = (i < 8 ? total : noise) ^ sb.len_mask;
      send_byte(word[(7 - i % 8) * 8 +: 8]);
    end
    repeat (payload_len) send_byte(stream_byte());
  endtask

  task automatic run_random(input int target);
    int          start;
    int          noise;
    int          body;
    int          pick;
    logic [63:0] total;
    logic [63:0] bad_noise;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      pick  = $urandom_range(99);
      noise = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0;
      body  = ($urandom_range(9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 20);
      if (64'(16 + noise + body) > 64'(sb.len_max)) begin
        noise = 0;
        body  = 0;
      end
      if (sb.len_max <= 200 && $urandom_range(7) == 0) begin
        noise = 0;
        body  = int'(sb.len_max) - HEADER_BYTES;
      end
      total = 64'(HEADER_BYTES + noise + body);
      if (pick < 70) begin
        send_frame(total, 64'(noise), noise + body);
      end else if (pick < 85) begin
        case ($urandom_range(3))
          0: begin
            total     = 64'($urandom_range(0, 15));
            bad_noise = 64'($urandom_range(0, 3));
          end
          1: begin
            total     = 64'(HEADER_BYTES + $urandom_range(0, 30));
            bad_noise = total - HDR_LEN + 64'($urandom_range(1, 8));
          end
          2: begin
            total     = 64'(sb.len_max) + 64'($urandom_range(1, 4));
            bad_noise = '0;
          end
          default: begin
            total     = {$urandom, $urandom};
            bad_noise = {$urandom, $urandom};
          end
        endcase
        send_frame(total, bad_noise, 0);
      end else if (pick < 93 && noise + body > 0) begin
        // Frame cut short; the block stays mid-frame and swallows what follows.
        send_frame(total, 64'(noise), $urandom_range(0, noise + body - 1));
      end else begin
        repeat ($urandom_range(1, 24)) send_byte(stream_byte());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset register values, no idling: one of each frame shape.
    send_frame(64'd16, 64'd0, 0);
    send_frame(64'd19, 64'd3, 3);
    send_frame(64'd17, 64'd0, 1);
    send_frame(64'd22, 64'd2, 6);
    send_frame(64'd15, 64'd0, 0);
    send_frame(64'd0, 64'd0, 0);
    send_frame(64'd20, 64'd5, 0);
    send_frame(64'd100, {64{1'b1}}, 0);
    send_frame({64{1'b1}}, 64'd0, 0);
    send_frame(64'(MAXLEN_RESET) + 64'd1, 64'd0, 0);
    send_frame(64'(MAXLEN_RESET), {64{1'b1}}, 0);
    settle_block();

    // Zero mask, largest length limit with junk in the unused upper data bits.
    write_reg(REG_MAGIC_MASK, 64'd0);
    write_reg(REG_MAX_FRAME_LEN, {$urandom, 32'hFFFF_FFFF});
    send_idle_pct = 75;
    send_frame(64'h0000_0001_0000_0000, 64'd0, 0);
    run_random(240);
    settle_block();

    // All-ones mask, smallest length limit: only empty frames pass.
    write_reg(REG_MAGIC_MASK, {64{1'b1}});
    write_reg(REG_MAX_FRAME_LEN, 64'd16);
    send_idle_pct  = 0;
    recv_stall_pct = 75;
    send_frame(64'd16, 64'd0, 0);
    send_frame(64'd17, 64'd0, 0);
    run_random(240);
    settle_block();

    // Random mask, small limit exercised right at and just past its edge.
    write_reg(REG_MAGIC_MASK, {$urandom, $urandom});
    write_reg(REG_MAX_FRAME_LEN, 64'd40);
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    send_frame(64'd40, 64'd0, 24);
    send_frame(64'd41, 64'd0, 0);
    send_frame(64'd40, 64'd24, 24);
    run_random(240);
    settle_block();

    // Writes to unused indexes must leave both registers alone.
    write_reg(REG_MAGIC_MASK, {$urandom, $urandom});
    write_reg(REG_MAX_FRAME_LEN, 64'(MAXLEN_RESET));
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, {$urandom, $urandom});
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(240);
    settle_block();

    write_reg(REG_MAGIC_MASK, {$urandom, $urandom});
    write_reg(REG_MAX_FRAME_LEN, 64'($urandom_range(16, 300)));
    send_idle_pct  = 11;
    recv_stall_pct = 75;
    run_random(240);
    settle_block();

    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
